// ----- rtl/core/aes_block_cipher_assert.svh -----
// Assertion macros for the AES block cipher.
`ifndef AES_BLOCK_CIPHER_ASSERT_SVH
`define AES_BLOCK_CIPHER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/aes_pkg.sv -----
// Package with AES tables, field helpers and shared constants.
`default_nettype none
package aes_pkg;
  localparam int unsigned NumCfg = 5;
  localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [2:0] CFG_KEY_P0 = 3'd1;
  localparam logic [2:0] CFG_KEY_P1 = 3'd2;
  localparam logic [2:0] CFG_KEY_P2 = 3'd3;
  localparam logic [2:0] CFG_KEY_P3 = 3'd4;
  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;

  typedef logic [7:0] byte_t;
  typedef logic [31:0] word_t;
  typedef logic [127:0] block_t;

  typedef struct packed {
    logic   func;
    word_t  w0;
    word_t  w1;
    word_t  w2;
    word_t  w3;
  } in_item_t;

  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
  } out_item_t;

  localparam logic [2047:0] SboxFlat = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  function automatic byte_t sbox(input byte_t a);
    return SboxFlat[2047 - 8*a -: 8];
  endfunction

  function automatic byte_t inv_sbox(input byte_t a);
    byte_t r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (sbox(byte_t'(i)) == a) r = byte_t'(i);
    end
    return r;
  endfunction

  function automatic byte_t xt(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic word_t sub_w(input word_t w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic word_t mix_w(input word_t w);
    byte_t a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3, a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3, xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  // InvMixColumns as the forward mix of a pre-conditioned column.
  function automatic word_t inv_mix_w(input word_t w);
    byte_t a0, a1, a2, a3, u, v;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    u = xt(xt(a0 ^ a2));
    v = xt(xt(a1 ^ a3));
    return mix_w({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  function automatic byte_t rcon(input logic [3:0] k);
    byte_t r;
    r = 8'h01;
    for (int i = 0; i < 10; i++) begin
      if (4'(i) < k) r = xt(r);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/aes_if.sv -----
// Valid/ready channel interface carrying a payload.
`default_nettype none
interface aes_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/aes_block_cipher.sv -----
// AES-128/192/256 block cipher with round keys held in a RAM.
//   channel | dir | payload
//   in_     | in  | func, in_word0..3
//   out_    | out | out_word0..3
//   cfg_    | in  | index 3 bits, data 64 bits
// After a key write, a schedule pass fills the round-key RAM with 44, 52 or 60 words, one
// word a cycle, while no block is taken. A block then runs one round per cycle through
// the single column-round unit, which reads four key words from the RAM each round. The
// result waits in an output register; a new block is taken only once the last block is
// done and that register is free.
// Reset is synchronous and starts a schedule pass.
`default_nettype none
`include "aes_block_cipher_assert.svh"
module aes_block_cipher
  import aes_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  aes_if.sink        in_ch,
  aes_if.source      out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam logic [1:0] ST_KEYS = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]  ks_r;
  logic [63:0] kp_r [4];
  logic [1:0]  st_r, st_nxt;

  // Round-key RAM: up to 15 rounds of four words each, filled one word a cycle through an accumulator.
  // The spare last entry is never written; reads of it, as after the final round, are never used.
  logic [127:0] rk_mem [16];
  logic [127:0] rk_q;
  logic [3:0]   rk_raddr;
  logic [5:0]   kw_cnt_r;
  word_t        kwin_r [8];
  logic [127:0] rk_acc_r;
  logic [3:0]   nk;
  logic [3:0]   nr;
  logic [5:0]   total;
  logic [3:0]   kmod_r;
  logic [3:0]   kdiv_r;

  always_comb begin
    unique case (ks_r)
      KS_128:  nk = 4'd4;
      KS_192:  nk = 4'd6;
      default: nk = 4'd8;
    endcase
    nr = nk + 4'd6;
    total = {nr + 4'd1, 2'b00};
  end

  // Key expansion: one word per cycle from a sliding window of Nk words.
  word_t kt, kw_new, kprev;
  logic [3:0] nk_m1;
  always_comb begin
    nk_m1 = nk - 4'd1;
    kprev = kwin_r[nk_m1[2:0]];
    kt = kprev;
    if (kmod_r == 4'd0) kt = sub_w({kprev[23:0], kprev[31:24]}) ^ {rcon(kdiv_r), 24'h0};
    else if (nk == 4'd8 && kmod_r == 4'd4) kt = sub_w(kprev);
    kw_new = kwin_r[0] ^ kt;
  end

  logic [3:0] rnd_r;
  logic       dec_r;
  block_t     s_r;
  logic       ov_r;
  out_item_t  o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r <= KS_128;
      for (int i = 0; i < 4; i++) kp_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_SIZE: ks_r <= cfg_data[1:0];
        CFG_KEY_P0:   kp_r[0] <= cfg_data;
        CFG_KEY_P1:   kp_r[1] <= cfg_data;
        CFG_KEY_P2:   kp_r[2] <= cfg_data;
        CFG_KEY_P3:   kp_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic kstart;
  assign kstart = cfg_we && cfg_index < 3'(NumCfg);

  always_ff @(posedge clk) begin
    if (!rst_n || kstart) begin
      kw_cnt_r <= '0;
    end else if (st_r == ST_KEYS) begin
      kw_cnt_r <= kw_cnt_r + 6'd1;
    end
  end

  // The first Nk words come from the registers, the rest from the window.
  word_t kword;
  always_comb begin
    if (kw_cnt_r < {2'b00, nk}) kword = kw_cnt_r[0] ? kp_r[kw_cnt_r[2:1]][31:0]
                                                    : kp_r[kw_cnt_r[2:1]][63:32];
    else kword = kw_new;
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_KEYS) begin
      for (int i = 0; i < 7; i++) begin
        if (4'(i) == nk - 4'd1) kwin_r[i] <= kword;
        else kwin_r[i] <= kwin_r[i + 1];
      end
      kwin_r[7] <= kword;
      rk_acc_r <= {rk_acc_r[95:0], kword};
      if (kw_cnt_r[1:0] == 2'd3) rk_mem[kw_cnt_r[5:2]] <= {rk_acc_r[95:0], kword};
      if (kw_cnt_r + 6'd1 < {2'b00, nk}) begin
        kmod_r <= 4'd1; kdiv_r <= 4'd0;
      end else if (kw_cnt_r + 6'd1 == {2'b00, nk}) begin
        kmod_r <= 4'd0; kdiv_r <= 4'd0;
      end else if (kmod_r == nk - 4'd1) begin
        kmod_r <= 4'd0; kdiv_r <= kdiv_r + 4'd1;
      end else begin
        kmod_r <= kmod_r + 4'd1;
      end
    end
  end

  logic in_fire, out_fire, last;
  assign in_ch.ready = (st_r == ST_IDLE) && !ov_r;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign last = (st_r == ST_RUN) && (rnd_r == nr);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_KEYS: if (kw_cnt_r == total - 6'd1) st_nxt = ST_IDLE;
      ST_IDLE: if (in_fire) st_nxt = ST_RUN;
      ST_RUN:  if (last) st_nxt = ST_IDLE;
      default: st_nxt = ST_KEYS;
    endcase
    if (kstart) st_nxt = ST_KEYS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_KEYS;
    else st_r <= st_nxt;
  end

  // Round counter: step 0 only adds the first key, steps 1..Nr are the rounds.
  // The key for each step is read from the RAM in the cycle before that step, the first one in the accepting cycle.
  always_comb begin
    if (st_r == ST_IDLE) rk_raddr = in_ch.data.func ? nr : 4'd0;
    else rk_raddr = dec_r ? nr - rnd_r - 4'd1 : rnd_r + 4'd1;
  end

  always_ff @(posedge clk) rk_q <= rk_mem[rk_raddr];

  // One round from state and key; the first step only adds the key and the last step skips the column mix.
  block_t sb, mixed, nxt;
  logic [3:0] step;
  always_comb begin
    step = rnd_r;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec_r)
          sb[127 - 32*c - 8*r -: 8] = inv_sbox(s_r[127 - 32*((c - r + 4) % 4) - 8*r -: 8]);
        else
          sb[127 - 32*c - 8*r -: 8] = sbox(s_r[127 - 32*((c + r) % 4) - 8*r -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (dec_r) mixed[127 - 32*c -: 32] = inv_mix_w(sb[127 - 32*c -: 32] ^ rk_q[127 - 32*c -: 32]);
      else mixed[127 - 32*c -: 32] = mix_w(sb[127 - 32*c -: 32]) ^ rk_q[127 - 32*c -: 32];
    end
    if (step == 4'd0) nxt = s_r ^ rk_q;
    else if (step == nr) nxt = sb ^ rk_q;
    else nxt = mixed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
    end else if (in_fire) begin
      rnd_r <= '0;
      dec_r <= in_ch.data.func;
      s_r <= {in_ch.data.w0, in_ch.data.w1, in_ch.data.w2, in_ch.data.w3};
    end else if (st_r == ST_RUN && !last) begin
      rnd_r <= rnd_r + 4'd1;
      s_r <= nxt;
    end
  end

  // The final round goes straight into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (last) begin
      ov_r <= 1'b1;
    end else if (out_fire) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last) o_r <= nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data = o_r;

  `AES_ASSERT_IMP(a_no_in_busy, st_r != ST_IDLE, !in_ch.ready)
  `AES_ASSERT_NXT(a_last_sets_valid, last, out_ch.valid)
  `AES_ASSERT_IMP(a_round_bound, st_r == ST_RUN, rnd_r <= nr)
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the AES block cipher: directed vectors, then random blocks.
`default_nettype none
module tb_top
  import aes_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 40;
  localparam int HoldCycles = 300;
  localparam int RandPhases = 20;
  localparam int PhaseItems = 97;

  localparam byte_t FwdSub[256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;
  localparam logic [1:0] KS_256 = 2'd2;
  localparam logic [1:0] KS_ODD = 2'd3;
  localparam block_t FipsPlain = 128'h00112233445566778899aabbccddeeff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes_if #(.payload_t(in_item_t)) in_ch (clk);
  aes_if #(.payload_t(out_item_t)) out_ch (clk);

  aes_block_cipher uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the key registers and the round keys derived from them.
  logic [1:0] shadow_ks;
  logic [63:0] shadow_key[4];
  word_t round_key[60];
  byte_t inv_sub[256];

  out_item_t expected_blocks[$];
  int mismatches = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;

  function automatic byte_t dbl(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) p ^= a;
      a = dbl(a);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic word_t sub_word(word_t w);
    return {FwdSub[w[31:24]], FwdSub[w[23:16]], FwdSub[w[15:8]], FwdSub[w[7:0]]};
  endfunction

  function automatic int key_words();
    return (shadow_ks == KS_128) ? 4 : (shadow_ks == KS_192) ? 6 : 8;
  endfunction

  task automatic expand_key();
    int nk;
    word_t t;
    byte_t rc;
    nk = key_words();
    rc = 8'h01;
    for (int i = 0; i < 8; i++) round_key[i] = i[0] ? shadow_key[i/2][31:0] : shadow_key[i/2][63:32];
    for (int i = nk; i < 4 * (nk + 7); i++) begin
      t = round_key[i-1];
      if (i % nk == 0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_word(t);
      end
      round_key[i] = round_key[i-nk] ^ t;
    end
  endtask

  function automatic out_item_t cipher_block(in_item_t it);
    byte_t s[16], t[16];
    word_t wd[4];
    byte_t a0, a1, a2, a3;
    int nr, rnd, src;
    out_item_t res;
    nr = key_words() + 6;
    wd = '{it.w0, it.w1, it.w2, it.w3};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) s[4*c+r] = wd[c][31-8*r -: 8];
    for (int step = 0; step <= nr; step++) begin
      rnd = (it.func == FUNC_DEC) ? nr - step : step;
      if (step > 0) begin
        // Substitution and row shift commute, so one pass serves both directions.
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            src = (it.func == FUNC_DEC) ? ((c - r + 4) & 3) : ((c + r) & 3);
            t[4*c+r] = (it.func == FUNC_DEC) ? inv_sub[s[4*src+r]] : FwdSub[s[4*src+r]];
          end
        s = t;
        if (it.func == FUNC_ENC && step < nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            s[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
            s[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
            s[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
            s[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) s[4*c+r] ^= round_key[4*rnd+c][31-8*r -: 8];
      if (it.func == FUNC_DEC && step > 0 && step < nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
          s[4*c+1] = gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
          s[4*c+2] = gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
          s[4*c+3] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
        end
      end
    end
    res.w0 = {s[0], s[1], s[2], s[3]};
    res.w1 = {s[4], s[5], s[6], s[7]};
    res.w2 = {s[8], s[9], s[10], s[11]};
    res.w3 = {s[12], s[13], s[14], s[15]};
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pick_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_KEY_SIZE) shadow_ks = val[1:0];
    else if (idx <= CFG_KEY_P3) shadow_key[idx - 1] = val;
    expand_key();
  endtask

  task automatic wait_idle();
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Offers one block and returns once the transaction has been accepted and any random gap has passed.
  task automatic send_block(in_item_t it, bit known, out_item_t ans);
    int n;
    @(negedge clk);
    in_ch.data = it;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_blocks.push_back(known ? ans : cipher_block(it));
    n = pick_gap();
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      n = pick_gap();
      if (n > 0) begin
        out_ch.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!(out_ch.valid && rst_n));
    end
  end

  always @(posedge clk) begin
    out_item_t exp_blk;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", out_ch.data);
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (out_ch.data.w0 !== exp_blk.w0 || out_ch.data.w1 !== exp_blk.w1 ||
            out_ch.data.w2 !== exp_blk.w2 || out_ch.data.w3 !== exp_blk.w3) begin
          mismatches++;
          if (mismatches <= 10) $display("block mismatch: expected %h got %h", exp_blk, out_ch.data);
        end
      end
    end
  end

  typedef struct {
    logic [1:0] ks;
    bit load_key;
    logic func;
    block_t blk;
    bit known;
    block_t ans;
  } vector_t;

  vector_t vectors[] = '{
    '{KS_128, 0, FUNC_ENC, '0, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{KS_128, 0, FUNC_DEC, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1, '0},
    '{KS_128, 1, FUNC_ENC, FipsPlain, 1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{KS_128, 0, FUNC_DEC, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1, FipsPlain},
    '{KS_128, 0, FUNC_ENC, '1, 0, '0},
    '{KS_128, 0, FUNC_DEC, '1, 0, '0},
    '{KS_192, 0, FUNC_ENC, FipsPlain, 1, 128'hdda97ca4864cdfe06eaf70a0ec0d7191},
    '{KS_192, 0, FUNC_DEC, 128'hdda97ca4864cdfe06eaf70a0ec0d7191, 1, FipsPlain},
    '{KS_192, 0, FUNC_ENC, '1, 0, '0},
    '{KS_192, 0, FUNC_DEC, '0, 0, '0},
    '{KS_256, 0, FUNC_ENC, FipsPlain, 1, 128'h8ea2b7ca516745bfeafc49904b496089},
    '{KS_256, 0, FUNC_DEC, 128'h8ea2b7ca516745bfeafc49904b496089, 1, FipsPlain},
    '{KS_256, 0, FUNC_ENC, '1, 0, '0},
    '{KS_256, 0, FUNC_DEC, '0, 0, '0},
    '{KS_ODD, 0, FUNC_ENC, FipsPlain, 1, 128'h8ea2b7ca516745bfeafc49904b496089},
    '{KS_ODD, 1, FUNC_DEC, 128'h8ea2b7ca516745bfeafc49904b496089, 1, FipsPlain},
    '{KS_ODD, 0, FUNC_ENC, 128'h0123456789abcdeffedcba9876543210, 0, '0}
  };

  initial begin
    in_item_t it;
    out_item_t ans;
    logic [1:0] ks_now;
    ks_now = KS_128;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    shadow_ks = KS_128;
    for (int i = 0; i < 4; i++) shadow_key[i] = '0;
    for (int i = 0; i < 256; i++) inv_sub[FwdSub[i]] = byte_t'(i);
    expand_key();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (vectors[v]) begin
      if (vectors[v].load_key || vectors[v].ks != ks_now) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        wait_idle();
        write_reg(CFG_KEY_SIZE, 64'(vectors[v].ks));
        ks_now = vectors[v].ks;
        if (vectors[v].load_key) begin
          write_reg(CFG_KEY_P0, 64'h0001020304050607);
          write_reg(CFG_KEY_P1, 64'h08090a0b0c0d0e0f);
          write_reg(CFG_KEY_P2, 64'h1011121314151617);
          write_reg(CFG_KEY_P3, 64'h18191a1b1c1d1e1f);
          // Writes past the last register must leave the key untouched.
          for (int k = 0; k < 3; k++) write_reg(3'(NumCfg + k), '1);
        end
      end
      {it.w0, it.w1, it.w2, it.w3} = vectors[v].blk;
      it.func = vectors[v].func;
      {ans.w0, ans.w1, ans.w2, ans.w3} = vectors[v].ans;
      send_block(it, vectors[v].known, ans);
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      wait_idle();
      gaps_on = (ph % 4 != 3);
      write_reg(CFG_KEY_SIZE, (ph < 3) ? 64'(KS_256 - ph) : 64'($urandom_range(0, 3)));
      write_reg(CFG_KEY_P0, pick_key());
      write_reg(CFG_KEY_P1, pick_key());
      write_reg(CFG_KEY_P2, pick_key());
      write_reg(CFG_KEY_P3, pick_key());
      if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(NumCfg, 7)), pick_key());
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 5 && n == 10) hold_req = 1'b1;
        it.func = $urandom_range(0, 1);
        it.w0 = $urandom;
        it.w1 = $urandom;
        it.w2 = $urandom;
        it.w3 = $urandom;
        send_block(it, 1'b0, ans);
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    wait_idle();
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("[aes_block_cipher] OK");
    end else begin
      $display("[aes_block_cipher] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[aes_block_cipher] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
